@@ hdl/lif_pkg.sv @@
// Shared types and constants for the LIF neuron array block.
// No dependencies; imported by every module and by the testbench.
package lif_pkg;

    localparam int NEURONS_DEF = 64;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFR  = 2'd3;

    // register reset values
    localparam logic signed [15:0] REST_RST  = -16'sd3932;
    localparam logic signed [15:0] THR_RST   = -16'sd3277;
    localparam logic [15:0]        SCALE_RST = 16'd328;
    localparam logic [15:0]        REFR_RST  = 16'd50;

    // membrane value every entry takes after reset
    localparam logic signed [15:0] MEM_RST = -16'sd3932;

    typedef enum logic [1:0] {
        FN_TICK   = 2'd0,
        FN_SET_BG = 2'd1,
        FN_LOAD   = 2'd2,
        FN_READ   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_WRITE
    } ctl_state_t;

    typedef struct packed {
        logic signed [15:0] mem;
        logic [15:0]        refc;
        logic signed [15:0] bg;
    } neuron_word_t;

    // controller -> datapath
    typedef struct packed {
        logic take_item;
        logic cnt_clr;
        logic cnt_inc;
        logic clr_wr;
        logic rd_en;
        logic calc_en;
        logic upd_en;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic cnt_last;
        logic out_free;
    } ctl_sts_t;

endpackage

@@ hdl/lif_if.sv @@
// Valid/ready channel interfaces for command words and result words.
// Does not depend on lif_pkg.
interface lif_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [5:0]         neuron;
    logic signed [15:0] value;
    logic [15:0]        ref_load;

    modport source (output valid, output func, output neuron, output value,
                    output ref_load, input ready);
    modport sink (input valid, input func, input neuron, input value,
                  input ref_load, output ready);
endinterface

interface lif_res_if;
    logic               valid;
    logic               ready;
    logic [5:0]         out_neuron;
    logic               spiked;
    logic signed [15:0] membrane;
    logic [15:0]        ref_count;
    logic signed [15:0] background;
    logic               last;

    modport source (output valid, output out_neuron, output spiked, output membrane,
                    output ref_count, output background, output last, input ready);
    modport sink (input valid, input out_neuron, input spiked, input membrane,
                  input ref_count, input background, input last, output ready);
endinterface

@@ hdl/lif_ctrl.sv @@
// Sequencer for the LIF neuron array: clear pass, accept, read/calc/write per neuron.
// Depends on lif_pkg (state enum, command and status structs).
module lif_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  lif_pkg::ctl_sts_t sts,
    output lif_pkg::ctl_cmd_t ctl
);
    import lif_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (sts.out_free)
                begin
                    if (sts.is_tick && !sts.cnt_last)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        cmd_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_wr  = 1'b1;
                ctl.cnt_clr = sts.cnt_last;
                ctl.cnt_inc = !sts.cnt_last;
            end
            ST_IDLE:
            begin
                cmd_ready     = 1'b1;
                ctl.take_item = cmd_valid;
                ctl.cnt_clr   = cmd_valid;
            end
            ST_READ:
            begin
                ctl.rd_en = 1'b1;
            end
            ST_CALC:
            begin
                ctl.calc_en = 1'b1;
            end
            ST_WRITE:
            begin
                ctl.upd_en  = sts.out_free;
                ctl.cnt_inc = sts.out_free && sts.is_tick && !sts.cnt_last;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

@@ hdl/lif_dpath.sv @@
// Datapath: config registers, neuron state memory, Euler update and result register.
// Depends on lif_pkg and lif_res_if; driven by lif_ctrl commands.
module lif_dpath #(
    parameter int NEURONS = lif_pkg::NEURONS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lif_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lif_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [1:0]                        cmd_func,
    input  logic [5:0]                        cmd_neuron,
    input  logic signed [15:0]                cmd_value,
    input  logic [15:0]                       cmd_ref_load,
    input  lif_pkg::ctl_cmd_t                 ctl,
    output lif_pkg::ctl_sts_t                 sts,
    lif_res_if.source                         res
);
    import lif_pkg::*;

    localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

    // configuration
    logic signed [15:0] rest_reg;
    logic signed [15:0] thr_reg;
    logic [15:0]        scale_reg;
    logic [15:0]        refr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg  <= REST_RST;
            thr_reg   <= THR_RST;
            scale_reg <= SCALE_RST;
            refr_reg  <= REFR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REST:  rest_reg  <= $signed(cfg_data[15:0]);
                CFG_THR:   thr_reg   <= $signed(cfg_data[15:0]);
                CFG_SCALE: scale_reg <= cfg_data[15:0];
                CFG_REFR:  refr_reg  <= cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    // captured command word
    func_t              func_reg;
    logic [5:0]         idx_reg;
    logic signed [15:0] value_reg;
    logic [15:0]        rl_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.take_item)
        begin
            func_reg  <= func_t'(cmd_func);
            idx_reg   <= cmd_neuron;
            value_reg <= cmd_value;
            rl_reg    <= cmd_ref_load;
        end
    end

    // neuron walk counter (also sweeps the clear pass)
    logic [AW-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.cnt_clr)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.cnt_inc)
        begin
            cnt_reg <= cnt_reg + AW'(1);
        end
    end

    logic is_tick;
    logic in_range;
    logic cnt_last;
    logic [AW-1:0] addr;

    assign is_tick  = (func_reg == FN_TICK);
    assign in_range = (32'(idx_reg) < NEURONS);
    assign cnt_last = (cnt_reg == AW'(NEURONS - 1));
    assign addr     = (is_tick || ctl.clr_wr) ? cnt_reg : AW'(idx_reg);

    // state memory
    neuron_word_t mem_arr [NEURONS];
    neuron_word_t rd_word_reg;
    neuron_word_t wr_word;
    logic         wr_en;
    neuron_word_t rst_word;

    assign rst_word = '{mem: MEM_RST, refc: 16'd0, bg: 16'sd0};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_arr[addr] <= ctl.clr_wr ? rst_word : wr_word;
        end
        if (ctl.rd_en)
        begin
            rd_word_reg <= mem_arr[addr];
        end
    end

    // Euler step, product registered
    logic signed [17:0] diff;
    logic signed [34:0] prod_reg;

    assign diff = 18'(rest_reg) - 18'(rd_word_reg.mem) + 18'(rd_word_reg.bg);

    always_ff @(posedge clk)
    begin
        if (ctl.calc_en)
        begin
            prod_reg <= 35'(diff) * 35'($signed({1'b0, scale_reg}));
        end
    end

    logic signed [18:0] step;
    logic signed [19:0] sum;
    logic signed [15:0] sat_mem;
    logic               spk;
    neuron_word_t       tick_word;

    // upper bits of the product are the floor of the shift by 16
    assign step = prod_reg[34:16];
    assign sum  = 20'(rd_word_reg.mem) + 20'(step);

    always_comb
    begin
        if (sum > 20'sd32767)
        begin
            sat_mem = 16'sh7fff;
        end
        else if (sum < -20'sd32768)
        begin
            sat_mem = -16'sh8000;
        end
        else
        begin
            sat_mem = sum[15:0];
        end
    end

    always_comb
    begin
        tick_word = rd_word_reg;
        spk       = 1'b0;
        if (rd_word_reg.refc != 16'd0)
        begin
            tick_word.refc = rd_word_reg.refc - 16'd1;
            tick_word.mem  = rest_reg;
        end
        else if (sat_mem > thr_reg)
        begin
            spk            = 1'b1;
            tick_word.mem  = rest_reg;
            tick_word.refc = refr_reg;
        end
        else
        begin
            tick_word.mem = sat_mem;
        end
    end

    always_comb
    begin
        wr_word = rd_word_reg;
        case (func_reg)
            FN_TICK:   wr_word = tick_word;
            FN_SET_BG: wr_word.bg = value_reg;
            FN_LOAD:
            begin
                wr_word.mem  = value_reg;
                wr_word.refc = rl_reg;
            end
            FN_READ:   wr_word = rd_word_reg;
            default:   wr_word = rd_word_reg;
        endcase
    end

    assign wr_en = ctl.clr_wr || (ctl.upd_en && (is_tick || in_range));

    // result register
    logic               res_valid_reg;
    logic [5:0]         res_neuron_reg;
    logic               res_spiked_reg;
    logic signed [15:0] res_mem_reg;
    logic [15:0]        res_ref_reg;
    logic signed [15:0] res_bg_reg;
    logic               res_last_reg;
    logic               out_free;

    assign out_free = !res_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.upd_en)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.upd_en)
        begin
            res_neuron_reg <= is_tick ? 6'(cnt_reg) : idx_reg;
            res_spiked_reg <= is_tick && spk;
            res_last_reg   <= !is_tick || cnt_last;
            if (is_tick || in_range)
            begin
                res_mem_reg <= wr_word.mem;
                res_ref_reg <= wr_word.refc;
                res_bg_reg  <= wr_word.bg;
            end
            else
            begin
                res_mem_reg <= '0;
                res_ref_reg <= '0;
                res_bg_reg  <= '0;
            end
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.out_neuron = res_neuron_reg;
    assign res.spiked     = res_spiked_reg;
    assign res.membrane   = res_mem_reg;
    assign res.ref_count  = res_ref_reg;
    assign res.background = res_bg_reg;
    assign res.last       = res_last_reg;

    assign sts.is_tick  = is_tick;
    assign sts.cnt_last = cnt_last;
    assign sts.out_free = out_free;

endmodule

@@ hdl/lif_neuron_array_update.sv @@
// Top level of the LIF neuron array: controller plus datapath.
// Depends on lif_pkg, lif_if (lif_cmd_if, lif_res_if), lif_ctrl and lif_dpath.
//
// Array of NEURONS current-based leaky integrate-and-fire neurons, each with a
// membrane value, refractory countdown and background current held in one
// single-port state memory. A tick command (func 0) walks every neuron in index
// order and returns one result word per neuron, last set on the final one; the
// other commands set a background current, load a membrane and count, or read a
// neuron back, each returning one word. Indexes at or beyond NEURONS return a
// zeroed word and change nothing. One command is worked on at a time. Each
// neuron passes through a read, a multiply and a write step on the state
// memory, after the command has been accepted in the idle state; a stalled
// result port holds the write step only while the result register is still
// full. After reset the block runs a clearing pass over every memory entry
// with cmd.ready low; configuration writes are taken at any time and should
// only be issued while the block is idle.
module lif_neuron_array_update #(
    parameter int NEURONS = lif_pkg::NEURONS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lif_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lif_pkg::CFG_DATA_W-1:0] cfg_data,
    lif_cmd_if.sink                        cmd,
    lif_res_if.source                      res
);
    import lif_pkg::*;

    ctl_cmd_t ctl;
    ctl_sts_t sts;
    logic     cmd_ready;

    // sequencer: clear pass, command accept, per-neuron read/calc/write
    lif_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    assign cmd.ready = cmd_ready;

    // config regs, state memory, Euler arithmetic, result register
    lif_dpath #(
        .NEURONS (NEURONS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_func     (cmd.func),
        .cmd_neuron   (cmd.neuron),
        .cmd_value    (cmd.value),
        .cmd_ref_load (cmd.ref_load),
        .ctl          (ctl),
        .sts          (sts),
        .res          (res)
    );

    // one command at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("command accepted while previous one in flight");

    // a pending non-final word means a tick is still walking
    a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.last |-> !cmd.ready)
        else $error("command port open during tick");

    // a spike on a final word can only be the top neuron of a tick
    a_spike_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.last && res.spiked |-> res.out_neuron == 6'(NEURONS - 1))
        else $error("spike flagged on non-tick result");

endmodule

@@ tb/sv/tb_lif_neuron_array_update.sv @@
// Self-checking testbench for lif_neuron_array_update: a scripted bring-up table, then six
// randomized phases, each under its own register setting, checked against a local neuron model.
// Depends on lif_pkg and lif_if (lif_cmd_if, lif_res_if) from the RTL.
module tb_lif_neuron_array_update;
    timeunit 1ns;
    timeprecision 1ps;

    import lif_pkg::*;

    localparam int NEURONS = NEURONS_DEF;
    localparam int PHASE_WORDS = 50;

    // One report word as the block should return it.
    typedef struct {
        logic [5:0]         nrn;
        logic               spiked;
        logic signed [15:0] mem;
        logic [15:0]        refc;
        logic signed [15:0] bg;
        logic               last;
    } neuron_report_t;

    // One command word. Where has_fixed is set, the answer is typed into the row itself.
    typedef struct {
        func_t              fn;
        logic [5:0]         nrn;
        logic signed [15:0] val;
        logic [15:0]        rl;
        bit                 has_fixed;
        logic signed [15:0] e_mem;
        logic [15:0]        e_ref;
        logic signed [15:0] e_bg;
    } command_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lif_cmd_if cmd_ch();
    lif_res_if res_ch();

    lif_neuron_array_update #(.NEURONS(NEURONS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // Local copy of the registers and of the neuron array.
    logic signed [15:0] rest_lvl;
    logic signed [15:0] fire_thr;
    logic [15:0]        mem_scale;
    logic [15:0]        refr_ticks;
    logic signed [15:0] mem_st [NEURONS];
    logic [15:0]        refr_st [NEURONS];
    logic signed [15:0] bg_st [NEURONS];

    neuron_report_t neuron_reports [$];  // report words still owed by the block
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;                 // long result-side stall, in cycles

    // Scripted bring-up under reset settings (rest -3932, threshold -3277, scale 328,
    // 50 refractory ticks). Fixed answers are given only where they are obvious.
    command_row_t bringup_rows [20] = '{
        // reset contents at both ends of the array
        '{FN_READ,   6'd0,  16'sd0,      16'd0,     1'b1, -16'sd3932,  16'd0,     16'sd0},
        '{FN_READ,   6'd63, 16'sd0,      16'd0,     1'b1, -16'sd3932,  16'd0,     16'sd0},
        '{FN_TICK,   6'd0,  16'sd0,      16'd0,     1'b0,  16'sd0,     16'd0,     16'sd0},
        // background extremes
        '{FN_SET_BG, 6'd63, 16'sd32767,  16'd0,     1'b1, -16'sd3932,  16'd0,     16'sd32767},
        '{FN_SET_BG, 6'd0,  -16'sd32768, 16'd0,     1'b1, -16'sd3932,  16'd0,    -16'sd32768},
        // membrane and countdown extremes
        '{FN_LOAD,   6'd1,  -16'sd32768, 16'hFFFF,  1'b1, -16'sd32768, 16'hFFFF,  16'sd0},
        '{FN_LOAD,   6'd2,  16'sd32767,  16'd0,     1'b1,  16'sd32767, 16'd0,     16'sd0},
        '{FN_LOAD,   6'd3,  -16'sd3000,  16'd1,     1'b1, -16'sd3000,  16'd1,     16'sd0},
        '{FN_SET_BG, 6'd4,  16'sd700,    16'd0,     1'b1, -16'sd3932,  16'd0,     16'sd700},
        '{FN_TICK,   6'd0,  16'sd0,      16'd0,     1'b0,  16'sd0,     16'd0,     16'sd0},
        '{FN_READ,   6'd2,  16'sd0,      16'd0,     1'b0,  16'sd0,     16'd0,     16'sd0},
        '{FN_TICK,   6'd0,  16'sd0,      16'd0,     1'b0,  16'sd0,     16'd0,     16'sd0},
        // alternating bit patterns
        '{FN_LOAD,   6'd21, 16'sh5555,   16'hAAAA,  1'b1,  16'sh5555,  16'hAAAA,  16'sd0},
        '{FN_LOAD,   6'd42, 16'shAAAA,   16'h5555,  1'b1,  16'shAAAA,  16'h5555,  16'sd0},
        '{FN_SET_BG, 6'd42, 16'sh5555,   16'd0,     1'b1,  16'shAAAA,  16'h5555,  16'sh5555},
        '{FN_TICK,   6'd0,  16'sd0,      16'd0,     1'b0,  16'sd0,     16'd0,     16'sd0},
        '{FN_READ,   6'd42, 16'sd0,      16'd0,     1'b0,  16'sd0,     16'd0,     16'sd0},
        // Euler step down from the top with the strongest negative drive
        '{FN_LOAD,   6'd0,  16'sd32767,  16'd0,     1'b1,  16'sd32767, 16'd0,    -16'sd32768},
        '{FN_TICK,   6'd0,  16'sd0,      16'd0,     1'b0,  16'sd0,     16'd0,     16'sd0},
        '{FN_READ,   6'd1,  16'sd0,      16'd0,     1'b0,  16'sd0,     16'd0,     16'sd0}
    };

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Whole-run time limit, far above the slowest legal run.
    initial
    begin
        #24ms;
        $display("end of test: mismatches");
        $finish;
    end

    // Neuron model: applies one command to the local array and queues the report words
    // that it causes. A tick does a floor-shifted Euler step per neuron, saturates to 16
    // bits, and fires when the new membrane is strictly above threshold.
    task automatic run_neurons(input func_t fn, input logic [5:0] nrn,
                               input logic signed [15:0] val, input logic [15:0] rl);
        neuron_report_t rep;
        longint drive;
        longint nxt;
        int i;
        if (fn == FN_TICK)
        begin
            for (i = 0; i < NEURONS; i++)
            begin
                rep.spiked = 1'b0;
                if (refr_st[i] == 16'd0)
                begin
                    drive = longint'(rest_lvl) - longint'(mem_st[i]) + longint'(bg_st[i]);
                    nxt = longint'(mem_st[i]) + ((drive * longint'(mem_scale)) >>> 16);
                    if (nxt > 32767)
                        nxt = 32767;
                    else if (nxt < -32768)
                        nxt = -32768;
                    if (nxt > longint'(fire_thr))
                    begin
                        rep.spiked = 1'b1;
                        mem_st[i] = rest_lvl;
                        refr_st[i] = refr_ticks;
                    end
                    else
                        mem_st[i] = nxt[15:0];
                end
                else
                begin
                    // refractory: count down, membrane pinned at rest
                    refr_st[i] = refr_st[i] - 16'd1;
                    mem_st[i] = rest_lvl;
                end
                rep.nrn = i[5:0];
                rep.mem = mem_st[i];
                rep.refc = refr_st[i];
                rep.bg = bg_st[i];
                rep.last = (i == NEURONS - 1);
                neuron_reports.push_back(rep);
            end
        end
        else
        begin
            if (fn == FN_SET_BG)
                bg_st[nrn] = val;
            else if (fn == FN_LOAD)
            begin
                mem_st[nrn] = val;
                refr_st[nrn] = rl;
            end
            rep.nrn = nrn;
            rep.spiked = 1'b0;
            rep.mem = mem_st[nrn];
            rep.refc = refr_st[nrn];
            rep.bg = bg_st[nrn];
            rep.last = 1'b1;
            neuron_reports.push_back(rep);
        end
    endtask

    // Called at a falling edge. Writes all four registers, one per cycle, and mirrors them.
    task automatic load_settings(input logic [15:0] rest, input logic [15:0] thr,
                                 input logic [15:0] scale, input logic [15:0] refr);
        cfg_we = 1'b1;
        cfg_index = CFG_REST;
        cfg_data = rest;
        @(negedge clk);
        cfg_index = CFG_THR;
        cfg_data = thr;
        @(negedge clk);
        cfg_index = CFG_SCALE;
        cfg_data = scale;
        @(negedge clk);
        cfg_index = CFG_REFR;
        cfg_data = refr;
        @(negedge clk);
        cfg_we = 1'b0;
        rest_lvl = rest;
        fire_thr = thr;
        mem_scale = scale;
        refr_ticks = refr;
    endtask

    // Called at a falling edge. Offers one word, possibly after random idle cycles, and
    // returns at the falling edge after it was taken. The model runs at that falling edge,
    // so it never shares a time step with a report word.
    task automatic send_word(input command_row_t row);
        neuron_report_t fixed;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid = 1'b1;
        cmd_ch.func = row.fn;
        cmd_ch.neuron = row.nrn;
        cmd_ch.value = row.val;
        cmd_ch.ref_load = row.rl;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
        run_neurons(row.fn, row.nrn, row.val, row.rl);
        if (row.has_fixed)
        begin
            // the model still updates its array; the typed answer replaces its report word
            fixed = neuron_reports.pop_back();
            fixed.mem = row.e_mem;
            fixed.refc = row.e_ref;
            fixed.bg = row.e_bg;
            fixed.spiked = 1'b0;
            fixed.last = 1'b1;
            fixed.nrn = row.nrn;
            neuron_reports.push_back(fixed);
        end
    endtask

    // Stop offering and let every owed word come back, then idle before returning at a falling edge.
    task automatic wait_drained();
        cmd_ch.valid = 1'b0;
        while (neuron_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    // Random command. Indexes lean on a few low neurons so that state builds up; about half
    // of the currents and membranes sit near the threshold, so that neurons cross it.
    function automatic command_row_t random_word();
        command_row_t row;
        int pick;
        int target;
        pick = $urandom_range(99);
        if (pick < 40)
            row.fn = FN_TICK;
        else if (pick < 65)
            row.fn = FN_SET_BG;
        else if (pick < 85)
            row.fn = FN_LOAD;
        else
            row.fn = FN_READ;
        row.nrn = ($urandom_range(1) == 0) ? 6'($urandom) : 6'($urandom_range(7));
        if ($urandom_range(1) == 0)
            row.val = 16'($urandom);
        else
        begin
            if (row.fn == FN_SET_BG)
                target = int'(fire_thr) - int'(rest_lvl);   // settles right at threshold
            else
                target = int'(fire_thr);
            target = target + int'($urandom_range(400)) - 200;
            if (target > 32767)
                target = 32767;
            else if (target < -32768)
                target = -32768;
            row.val = target[15:0];
        end
        row.rl = ($urandom_range(9) < 7) ? 16'($urandom_range(3)) : 16'($urandom);
        row.has_fixed = 1'b0;
        row.e_mem = '0;
        row.e_ref = '0;
        row.e_bg = '0;
        return row;
    endfunction

    // Result side: random stalls, or one long hold counted here when requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                res_ch.ready = 1'b0;
                hold_left--;
            end
            else
                res_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic signed [16:0] want,
                               input logic signed [16:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Every report word taken is matched against the oldest word owed.
    always @(posedge clk)
    begin
        neuron_report_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (neuron_reports.size() == 0)
            begin
                $display("%0t ns: unexpected word for neuron %0d", $time, res_ch.out_neuron);
                mismatch_count++;
            end
            else
            begin
                want = neuron_reports.pop_front();
                check_field("out_neuron", want.nrn, res_ch.out_neuron);
                check_field("spiked", want.spiked, res_ch.spiked);
                check_field("membrane", want.mem, res_ch.membrane);
                check_field("ref_count", want.refc, res_ch.ref_count);
                check_field("background", want.bg, res_ch.background);
                check_field("last", want.last, res_ch.last);
            end
        end
    end

    // Main sequence: reset, bring-up table, six register settings with random words, drain.
    initial
    begin
        int ph;
        int k;
        int spins;
        logic signed [15:0] rest;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_REST;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.func = FN_TICK;
        cmd_ch.neuron = '0;
        cmd_ch.value = '0;
        cmd_ch.ref_load = '0;

        rest_lvl = REST_RST;
        fire_thr = THR_RST;
        mem_scale = SCALE_RST;
        refr_ticks = REFR_RST;
        for (k = 0; k < NEURONS; k++)
        begin
            mem_st[k] = MEM_RST;
            refr_st[k] = '0;
            bg_st[k] = '0;
        end

        repeat (12) @(negedge clk);
        rst_n = 1'b1;   // the block clears its array next; cmd.ready stays low meanwhile

        send_idle_pct = 34;
        recv_idle_pct = 75;
        foreach (bringup_rows[k])
            send_word(bringup_rows[k]);
        wait_drained();

        for (ph = 0; ph < 6; ph++)
        begin
            // receiver-heavy idling first, then sender-heavy, then none at all
            send_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 75 : 0;
            recv_idle_pct = (ph < 2) ? 75 : (ph < 4) ? 34 : 0;
            case (ph)
                // everything above the floor fires; zero refractory, near-full-step Euler (scale 0xFFFF)
                0: load_settings(16'h8000, 16'h8000, 16'hFFFF, 16'd0);
                // nothing can exceed the top threshold; longest refractory
                1: load_settings(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
                // zero scale: membranes never move except through loads, spikes and refractory ticks
                2: load_settings(16'($urandom), 16'($urandom), 16'd0, 16'($urandom_range(3)));
                5: load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                default:
                begin
                    rest = -16'($urandom_range(8000));
                    load_settings(rest, rest + 16'($urandom_range(3000)),
                                  16'($urandom_range(65535, 2000)), 16'($urandom_range(4)));
                end
            endcase

            // long result-side hold while ticks keep coming, to back the block up
            if (ph == 3)
                hold_request = 400;

            for (k = 0; k < PHASE_WORDS; k++)
            begin
                // one pause mid-phase until every owed word is back
                if (ph == 2 && k == PHASE_WORDS / 2)
                    wait_drained();
                send_word(random_word());
            end
            wait_drained();
        end

        // nothing more to send; wait out the owed words, then keep watching for stray words
        cmd_ch.valid = 1'b0;
        spins = 0;
        while (neuron_reports.size() != 0 && spins < 200000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (3 * NEURONS + 20) @(posedge clk);
        if (neuron_reports.size() != 0)
        begin
            $display("%0t ns: %0d words never arrived", $time, neuron_reports.size());
            mismatch_count += neuron_reports.size();
        end
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/lif_pkg.sv
hdl/lif_if.sv
hdl/lif_ctrl.sv
hdl/lif_dpath.sv
hdl/lif_neuron_array_update.sv
tb/sv/tb_lif_neuron_array_update.sv
